// ===== rtl/core/bdsl_pkg.sv =====
// Shared types and constants for the button debouncer with short/long press detection.
// Holds the payload structs, the register map, the register reset values and the state layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdsl_pkg;

  // time and register widths
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = CFG_IDX_W'(1);

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = CFG_W'(50);
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = CFG_W'(1000);

  // input beat
  typedef struct packed {
    logic              raw_pressed;
    logic [TIME_W-1:0] now_ms;
  } bdsl_in_t;

  // result beat
  typedef struct packed {
    logic stable_pressed;
    logic short_press;
    logic long_press;
  } bdsl_out_t;

  // configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } bdsl_cfg_t;

  // debouncer state carried from one update to the next
  typedef struct packed {
    logic              last_raw;
    logic              stable_level;
    logic [TIME_W-1:0] last_change_time;
    logic [TIME_W-1:0] press_start_time;
    logic              long_reported;
  } bdsl_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdsl_cfg.sv =====
// Configuration register file: debounce time and long-press time.
// Depends on bdsl_pkg for the register map, reset values and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module bdsl_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [bdsl_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [bdsl_pkg::CFG_W-1:0]     wr_data,
  output bdsl_pkg::bdsl_cfg_t                cfg
);

  bdsl_pkg::bdsl_cfg_t cfg_r;
  bdsl_pkg::bdsl_cfg_t cfg_nxt;

  // decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        bdsl_pkg::REG_DEBOUNCE_TIME:   cfg_nxt.debounce_time   = wr_data;
        bdsl_pkg::REG_LONG_PRESS_TIME: cfg_nxt.long_press_time = wr_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= bdsl_pkg::DEBOUNCE_TIME_RST;
      cfg_r.long_press_time <= bdsl_pkg::LONG_PRESS_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/bdsl_step.sv =====
// Combinational update for one sample: debounce window, stable level, press events.
// Depends on bdsl_pkg for the state, config and payload structs.
`timescale 1ns / 1ps
`default_nettype none

module bdsl_step (
  input  wire bdsl_pkg::bdsl_in_t    in_beat,
  input  wire bdsl_pkg::bdsl_cfg_t   cfg,
  input  wire bdsl_pkg::bdsl_state_t state_cur,
  output bdsl_pkg::bdsl_state_t      state_nxt,
  output bdsl_pkg::bdsl_out_t        result
);

  logic                        raw_chg;
  logic [bdsl_pkg::TIME_W-1:0] change_time;
  logic [bdsl_pkg::TIME_W-1:0] since_change;
  logic                        window_done;
  logic [bdsl_pkg::TIME_W-1:0] held_old;
  logic [bdsl_pkg::TIME_W-1:0] held_new;
  logic                        level_flip;
  logic                        short_ev;
  logic                        long_ev;

  always_comb begin
    state_nxt = state_cur;

    // raw change restarts the debounce window
    raw_chg     = in_beat.raw_pressed != state_cur.last_raw;
    change_time = raw_chg ? in_beat.now_ms : state_cur.last_change_time;
    state_nxt.last_raw         = in_beat.raw_pressed;
    state_nxt.last_change_time = change_time;

    // window check, modulo 2^32 difference
    since_change = in_beat.now_ms - change_time;
    window_done  = since_change >= {{(bdsl_pkg::TIME_W-bdsl_pkg::CFG_W){1'b0}},
                                    cfg.debounce_time};

    // hold time against the press start before this update
    held_old   = in_beat.now_ms - state_cur.press_start_time;
    level_flip = window_done && (in_beat.raw_pressed != state_cur.stable_level);
    short_ev   = 1'b0;
    held_new   = held_old;

    // stable level follows raw after the window
    if (level_flip) begin
      state_nxt.stable_level = in_beat.raw_pressed;
      if (in_beat.raw_pressed) begin
        state_nxt.press_start_time = in_beat.now_ms;
        state_nxt.long_reported    = 1'b0;
        held_new                   = '0;
      end else begin
        short_ev = !state_cur.long_reported &&
                   (held_old < {{(bdsl_pkg::TIME_W-bdsl_pkg::CFG_W){1'b0}},
                                cfg.long_press_time});
        state_nxt.press_start_time = '0;
      end
    end

    // long press fires once per press
    long_ev = window_done && state_nxt.stable_level && !state_nxt.long_reported &&
              (held_new >= {{(bdsl_pkg::TIME_W-bdsl_pkg::CFG_W){1'b0}},
                            cfg.long_press_time});
    if (long_ev) begin
      state_nxt.long_reported = 1'b1;
    end

    result.stable_pressed = state_nxt.stable_level;
    result.short_press    = short_ev;
    result.long_press     = long_ev;
  end

endmodule

`default_nettype wire

// ===== rtl/core/button_debounce_short_long_press.sv =====
// Button debouncer with short-press and long-press detection, top level.
// Instantiates bdsl_cfg and bdsl_step; uses bdsl_pkg types.
//
// Usage:
//   in_*   : one beat per sample, raw level plus free-running ms time.
//   out_*  : one beat per input beat, debounced level and one-beat
//            short_press / long_press pulses, in input order.
//   cfg_*  : register writes, index 0 debounce_time, index 1 long_press_time;
//            other indexes are ignored. Write only while no beat is in flight.
// Path: an accepted beat lands in the input register, and its result is then
//   captured in the result register, which drives out_*.
// Throughput: one beat per cycle while out_ready is high; the state update is
//   a single subtract-and-compare pass between input and result registers.
// Stall: when out_ready is low the result register holds, an empty input
//   register takes one more beat, then in_ready drops until the result drains.
// Reset: synchronous, active low; state returns to released with zero times,
//   registers return to 50 ms and 1000 ms, no beats are in flight.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_short_long_press (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire bdsl_pkg::bdsl_in_t             in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output bdsl_pkg::bdsl_out_t                 out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bdsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdsl_pkg::CFG_W-1:0]     cfg_wdata
);

  bdsl_pkg::bdsl_cfg_t   cfg;
  logic                  s1_valid_r;
  bdsl_pkg::bdsl_in_t    s1_data_r;
  bdsl_pkg::bdsl_state_t state_r;
  bdsl_pkg::bdsl_state_t state_nxt;
  bdsl_pkg::bdsl_out_t   result;
  logic                  out_valid_r;
  bdsl_pkg::bdsl_out_t   out_data_r;
  logic                  advance;

  // configuration registers
  assign cfg_ready = 1'b1;

  bdsl_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // pipeline flow control
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // per-sample update
  bdsl_step u_step (
    .in_beat   (s1_data_r),
    .cfg       (cfg),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // debouncer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/press_event_checker.sv =====
// Checker for the button debouncer: watches the input, result and register write channels.
// Predicts debounced level and press events per accepted beat; needs bdsl_pkg.
`timescale 1ns / 1ps

module press_event_checker
  import bdsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  bdsl_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  bdsl_out_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  // predictor copy of registers and debouncer state
  bdsl_cfg_t   regs;
  bdsl_state_t btn;

  // results still owed by the block, oldest first
  bdsl_out_t   expected_events[$];
  int          failures = 0;
  int          owed = 0;

  assign fail_count = failures;
  assign pending    = owed;

  // one update of the debouncer, returns the result beat it causes
  function automatic bdsl_out_t predict_press_events(input bdsl_in_t beat);
    bdsl_out_t         res;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    res = '0;
    // a raw change restarts the debounce window
    if (beat.raw_pressed != btn.last_raw) begin
      btn.last_change_time = beat.now_ms;
      btn.last_raw         = beat.raw_pressed;
    end
    since_change = beat.now_ms - btn.last_change_time;
    if (since_change >= TIME_W'(regs.debounce_time)) begin
      if (beat.raw_pressed != btn.stable_level) begin
        btn.stable_level = beat.raw_pressed;
        if (btn.stable_level) begin
          btn.press_start_time = beat.now_ms;
          btn.long_reported    = 1'b0;
        end else begin
          // release before the long-press limit counts as a short press
          held = beat.now_ms - btn.press_start_time;
          if (!btn.long_reported && held < TIME_W'(regs.long_press_time)) begin
            res.short_press = 1'b1;
          end
          btn.press_start_time = '0;
        end
      end
      // long press fires once per press
      held = beat.now_ms - btn.press_start_time;
      if (btn.stable_level && !btn.long_reported &&
          held >= TIME_W'(regs.long_press_time)) begin
        res.long_press    = 1'b1;
        btn.long_reported = 1'b1;
      end
    end
    res.stable_pressed = btn.stable_level;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic exp_v, input logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      failures++;
    end
  endfunction

  // channel monitor, all handshakes sampled at the rising edge
  always @(posedge clk) begin
    bdsl_out_t exp_beat;
    if (!rst_n) begin
      regs.debounce_time   = DEBOUNCE_TIME_RST;
      regs.long_press_time = LONG_PRESS_TIME_RST;
      btn                  = '0;
      expected_events.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("result beat with no expectation waiting: %b", out_data);
          failures++;
        end else begin
          exp_beat = expected_events.pop_front();
          check_field("stable_pressed", exp_beat.stable_pressed, out_data.stable_pressed);
          check_field("short_press", exp_beat.short_press, out_data.short_press);
          check_field("long_press", exp_beat.long_press, out_data.long_press);
        end
      end
      // register writes, unmapped indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE_TIME:   regs.debounce_time   = cfg_wdata;
          REG_LONG_PRESS_TIME: regs.long_press_time = cfg_wdata;
          default: ;
        endcase
      end
      // accepted sample
      if (in_valid && in_ready) begin
        expected_events.push_back(predict_press_events(in_data));
      end
    end
    owed = expected_events.size();
  end

endmodule

// ===== tb/button_debounce_short_long_press_tb.sv =====
// Top of the button debouncer testbench: clock, reset, sample stimulus and verdict.
// Instantiates button_debounce_short_long_press and press_event_checker; needs bdsl_pkg.
`timescale 1ns / 1ps

module button_debounce_short_long_press_tb;
  import bdsl_pkg::*;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int PHASE_SAMPLES   = 170;
  localparam int NUM_PHASES      = 8;
  localparam int CFG_IDX_MAX     = 2 ** CFG_IDX_W - 1;
  localparam int CFG_MAX         = 2 ** CFG_W - 1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  bdsl_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  bdsl_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   cur_deb = int'(DEBOUNCE_TIME_RST);
  int                   cur_lp = int'(LONG_PRESS_TIME_RST);
  int                   samples_sent = 0;
  logic [TIME_W-1:0]    now_cursor = '0;

  button_debounce_short_long_press uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  press_event_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 80; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 80; end
      default:       begin idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  // one sample beat; valid stays high into the next call unless a gap is taken
  task automatic send_beat(input logic raw, input logic [TIME_W-1:0] now);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= bdsl_in_t'{raw, now};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic step_to(input logic raw, input logic [TIME_W-1:0] dt);
    now_cursor = now_cursor + dt;
    send_beat(raw, now_cursor);
  endtask

  // drop valid and wait until every owed result has drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // both registers, then a write to an unmapped index that must not land
  task automatic set_config(input int deb, input int lp);
    write_reg(REG_DEBOUNCE_TIME, CFG_W'(deb));
    write_reg(REG_LONG_PRESS_TIME, CFG_W'(lp));
    write_reg(CFG_IDX_W'($urandom_range(2, CFG_IDX_MAX)), CFG_W'($urandom));
    cfg_valid <= 1'b0;
    cur_deb = deb;
    cur_lp  = lp;
  endtask

  // gap that stays inside the debounce window when the window is nonzero, else zero
  function automatic logic [TIME_W-1:0] bounce_dt();
    return (cur_deb == 0) ? '0 : TIME_W'($urandom_range(0, cur_deb - 1));
  endfunction

  // gap for a held level, weighted toward the window and limit edges
  function automatic logic [TIME_W-1:0] hold_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return TIME_W'(cur_deb);
      3:       return TIME_W'(cur_lp);
      4:       return (cur_lp == 0) ? '0 : TIME_W'(cur_lp - 1);
      5, 6:    return TIME_W'($urandom_range(0, cur_deb));
      7, 8:    return TIME_W'($urandom_range(0, cur_lp));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // bouncy press, hold, bouncy release, settle
  task automatic press_episode();
    repeat ($urandom_range(0, 3)) begin
      step_to(1'b1, bounce_dt());
      step_to(1'b0, bounce_dt());
    end
    repeat ($urandom_range(1, 6)) step_to(1'b1, hold_dt());
    repeat ($urandom_range(0, 2)) begin
      step_to(1'b0, bounce_dt());
      step_to(1'b1, bounce_dt());
    end
    repeat ($urandom_range(1, 4)) step_to(1'b0, hold_dt());
  endtask

  // random levels and time jumps
  task automatic noise_burst();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        now_cursor = $urandom;
        send_beat(1'($urandom_range(0, 1)), now_cursor);
      end else begin
        step_to(1'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 2 * cur_deb + 1)));
      end
    end
  endtask

  initial begin
    int deb;
    int lp;
    int target;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_BOTH);

    // reset settings: bounce, settle, short press, long press, release after long
    send_beat(1'b0, 0);
    send_beat(1'b1, 10);
    send_beat(1'b0, 20);
    send_beat(1'b1, 30);
    send_beat(1'b1, 80);
    send_beat(1'b0, 500);
    send_beat(1'b0, 550);
    send_beat(1'b1, 600);
    send_beat(1'b1, 650);
    send_beat(1'b1, 1649);
    send_beat(1'b1, 1650);
    send_beat(1'b1, 1700);
    send_beat(1'b0, 1750);
    send_beat(1'b0, 1800);

    // zero window and zero limit: long press on the settling beat
    wait_drained();
    set_config(0, 0);
    send_beat(1'b1, 32'hFFFF_FFF0);
    send_beat(1'b0, 32'h0000_0005);
    send_beat(1'b1, 32'h0000_0006);

    // widest window and limit, across the time wrap
    wait_drained();
    set_config(CFG_MAX, CFG_MAX);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'h0000_FFFE);
    send_beat(1'b1, 32'h0001_0000);
    send_beat(1'b1, 32'h0002_FFFF);
    send_beat(1'b1, 32'h0003_FFFD);
    send_beat(1'b0, 32'h0003_FFFE);
    send_beat(1'b0, 32'h0004_FFFD);

    // random phases, each with its own settings and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       begin deb = 0;                 lp = 0;                   end
        1:       begin deb = CFG_MAX;           lp = CFG_MAX;             end
        2:       begin
          deb = int'(DEBOUNCE_TIME_RST);
          lp  = int'(LONG_PRESS_TIME_RST);
        end
        3:       begin deb = 3;                 lp = 10;                  end
        4:       begin deb = 0;                 lp = 25;                  end
        5:       begin deb = 10;                lp = 0;                   end
        6:       begin deb = $urandom_range(0, 200); lp = $urandom_range(0, 500); end
        default: begin deb = $urandom_range(0, CFG_MAX); lp = $urandom_range(0, CFG_MAX); end
      endcase
      set_config(deb, lp);
      set_idling(idle_mode_t'(p % 4));
      now_cursor = $urandom;
      target = samples_sent + PHASE_SAMPLES;
      while (samples_sent < target) begin
        if ($urandom_range(0, 99) < 15) noise_burst();
        else press_episode();
        if ($urandom_range(0, 99) < 3) wait_drained();
      end
    end

    // drain, then watch for stray beats before the verdict
    wait_drained();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bdsl_pkg.sv
rtl/core/bdsl_cfg.sv
rtl/core/bdsl_step.sv
rtl/core/button_debounce_short_long_press.sv
tb/press_event_checker.sv
tb/button_debounce_short_long_press_tb.sv
